// File: src/uid_pkg.sv
`default_nettype none
package uid_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef logic [31:0] t_crc_table [256];

    // status codes of a result
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_CHECK_FAIL  = 2'd1,
        ST_VENDOR_FAIL = 2'd2
    } t_status;

    // one identifier in flight, with the three running CRC registers
    typedef struct packed {
        logic [63:0] ts;
        logic [31:0] prod;
        logic [31:0] ser;
        logic [31:0] chk;
        logic [31:0] crc_chk;
        logic [31:0] crc_lo;
        logic [31:0] crc_hi;
    } t_item;

    // which side lanes a CRC stage advances
    typedef struct packed {
        logic lo;
        logic hi;
    } t_lane_en;

    function automatic t_crc_table gen_crc_table();
        t_crc_table tbl;
        logic [31:0] c;
        for (int n = 0; n < 256; n++) begin
            c = 32'(n);
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[n] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = gen_crc_table();

    // advance a reflected CRC register by one little-endian word, byte by byte
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        logic [7:0]  idx;
        c = crc;
        for (int i = 0; i < 4; i++) begin
            idx = c[7:0] ^ word[8*i +: 8];
            c   = CRC_TABLE[idx] ^ {8'h00, c[31:8]};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/uid_crc_stage.sv
`default_nettype none
module uid_crc_stage
    import uid_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    input  t_lane_en   i_lane_en,
    input  wire [31:0] i_word_chk,
    input  wire [31:0] i_word_lo,
    input  wire [31:0] i_word_hi,
    output logic       o_valid,
    input  wire        i_ready,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_item         = i_item;
        n_item.crc_chk = crc_word(i_item.crc_chk, i_word_chk);
        if (i_lane_en.lo) begin
            n_item.crc_lo = crc_word(i_item.crc_lo, i_word_lo);
        end
        if (i_lane_en.hi) begin
            n_item.crc_hi = crc_word(i_item.crc_hi, i_word_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// File: src/uid_check_stage.sv
`default_nettype none
module uid_check_stage
    import uid_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire [15:0] i_vendor,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  wire        i_ready,
    output t_status    o_status,
    output logic [63:0] o_ts,
    output logic [31:0] o_prod,
    output logic [31:0] o_ser
);

    logic        r_valid;
    t_status     r_status;
    logic [63:0] r_ts;
    logic [31:0] r_prod;
    logic [31:0] r_ser;

    t_status     n_status;
    logic [63:0] n_ts;
    logic [31:0] n_prod;
    logic [31:0] n_ser;
    logic [31:0] plain_prod;

    assign o_ready    = !r_valid || i_ready;
    assign plain_prod = i_item.prod ^ ~i_item.ser;

    always_comb begin
        n_status = ST_OK;
        n_ts     = '0;
        n_prod   = '0;
        n_ser    = '0;
        if ((i_item.crc_chk ^ ALL_ONES) != i_item.chk) begin
            n_status = ST_CHECK_FAIL;
        end else if (plain_prod[31:16] != i_vendor) begin
            n_status = ST_VENDOR_FAIL;
        end else begin
            n_ts   = i_item.ts ^ {i_item.crc_hi ^ ALL_ONES, i_item.crc_lo ^ ALL_ONES};
            n_prod = plain_prod;
            n_ser  = i_item.ser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_status <= n_status;
            r_ts     <= n_ts;
            r_prod   <= n_prod;
            r_ser    <= n_ser;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_ts     = r_ts;
    assign o_prod   = r_prod;
    assign o_ser    = r_ser;

endmodule
`default_nettype wire

// File: src/uid_unmask_and_check.sv
// Channel  | Dir | Handshake                      | Payload
// ---------+-----+--------------------------------+----------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata 160 b: identifier request
// m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata 128 b: plain fields, tuser: status
// cfg      | in  | i_cfg_valid / o_cfg_ready      | i_cfg_data 16 b: vendor code
//
// One request accepted per cycle while m_axis does not stall; four CRC word
// stages and one check/output stage follow in turn. The clock period is set
// by the CRC stages, each a chain of four byte-table lookups.
// Synchronous active-low reset clears the stage valid bits and the vendor
// code; payload registers are not reset.
// A stall on m_axis backs up stage by stage; nothing is dropped or repeated.
`default_nettype none
module uid_unmask_and_check
    import uid_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [63:0] masked_timestamp, [95:64] masked_production,
    // [127:96] serial_number, [159:128] check_word
    input  wire [159:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [63:0] plain_timestamp, [95:64] plain_production, [127:96] serial_out
    output logic [127:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [15:0]  i_cfg_data
);

    localparam int NSTAGE = 4;

    logic [15:0] r_vendor;

    // stage k input is item[k]; item[0] is the incoming request
    t_item      item  [NSTAGE+1];
    logic       vld   [NSTAGE+1];
    logic       rdy   [NSTAGE+1];
    logic [31:0] w_chk [NSTAGE];
    logic [31:0] w_lo  [NSTAGE];
    logic [31:0] w_hi  [NSTAGE];
    t_lane_en   lanes [NSTAGE];

    t_status    out_status;
    logic [63:0] out_ts;
    logic [31:0] out_prod;
    logic [31:0] out_ser;

    // config writes must be made only while idle; the block does not enforce this and takes them at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor <= '0;
        end else if (i_cfg_valid) begin
            r_vendor <= i_cfg_data;
        end
    end

    // unpack the request; all three CRC registers start at all ones
    always_comb begin
        item[0].ts      = s_axis_tdata[63:0];
        item[0].prod    = s_axis_tdata[95:64];
        item[0].ser     = s_axis_tdata[127:96];
        item[0].chk     = s_axis_tdata[159:128];
        item[0].crc_chk = ALL_ONES;
        item[0].crc_lo  = ALL_ONES;
        item[0].crc_hi  = ALL_ONES;
    end

    assign vld[0]        = s_axis_tvalid;
    assign s_axis_tready = rdy[0];

    // Word order per lane, after simplifying the masks:
    //   check: ts_lo, ts_hi, prod, ser
    //   lo   : ser,  prod      (low timestamp mask)
    //   hi   : prod, ser       (high timestamp mask)
    always_comb begin
        w_chk[0] = item[0].ts[31:0];
        w_lo[0]  = item[0].ser;
        w_hi[0]  = item[0].prod;
        lanes[0] = '{lo: 1'b1, hi: 1'b1};

        w_chk[1] = item[1].ts[63:32];
        w_lo[1]  = item[1].prod;
        w_hi[1]  = item[1].ser;
        lanes[1] = '{lo: 1'b1, hi: 1'b1};

        w_chk[2] = item[2].prod;
        w_lo[2]  = item[2].prod;
        w_hi[2]  = item[2].prod;
        lanes[2] = '{lo: 1'b0, hi: 1'b0};

        w_chk[3] = item[3].ser;
        w_lo[3]  = item[3].ser;
        w_hi[3]  = item[3].ser;
        lanes[3] = '{lo: 1'b0, hi: 1'b0};
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_crc
        uid_crc_stage u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (vld[k]),
            .o_ready    (rdy[k]),
            .i_item     (item[k]),
            .i_lane_en  (lanes[k]),
            .i_word_chk (w_chk[k]),
            .i_word_lo  (w_lo[k]),
            .i_word_hi  (w_hi[k]),
            .o_valid    (vld[k+1]),
            .i_ready    (rdy[k+1]),
            .o_item     (item[k+1])
        );
    end

    // compare, unmask and register the result
    uid_check_stage u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vendor (r_vendor),
        .i_valid  (vld[NSTAGE]),
        .o_ready  (rdy[NSTAGE]),
        .i_item   (item[NSTAGE]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_status (out_status),
        .o_ts     (out_ts),
        .o_prod   (out_prod),
        .o_ser    (out_ser)
    );

    assign m_axis_tdata = {out_ser, out_prod, out_ts};
    assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
